// ===== rtl/l1p_pkg.sv =====
// ----------------------------------------------------------------------------
// l1p_pkg
// Shared Q60 constants, pipeline latencies and types for the ln(1+x) core.
// ----------------------------------------------------------------------------
package l1p_pkg;

   localparam int QB = 60;
   localparam int MUL_LAT = 6;
   localparam int RED_LAT = 15;
   localparam logic [63:0] DEC17 = 64'd100000000000000000;

   typedef logic signed [63:0] q60_type;

   typedef struct packed {
      logic        oor;
      q60_type     t;
      logic [63:0] den;
      q60_type     res0;
   } red_out_type;

   // decimal fraction with 17 digits to Q60, nearest, ties up
   function automatic logic [63:0] dec_q(input logic [63:0] digits);
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] ip;
      rem = digits;
      quo = '0;
      ip  = '0;
      for (int i = 0; i < 7; i++) begin
         if (rem >= DEC17) begin
            rem = rem - DEC17;
            ip  = ip + 64'd1;
         end
      end
      for (int i = 0; i < QB; i++) begin
         rem = {rem[62:0], 1'b0};
         quo = {quo[62:0], 1'b0};
         if (rem >= DEC17) begin
            rem    = rem - DEC17;
            quo[0] = 1'b1;
         end
      end
      rem = {rem[62:0], 1'b0};
      if (rem >= DEC17) begin
         quo = quo + 64'd1;
      end
      return (ip << QB) + quo;
   endfunction

   // divider latency: magnitude, integer steps, fraction and round steps, sum, sign
   function automatic int div_lat(input int int_bits);
      return int_bits + QB + 4;
   endfunction

   localparam logic [63:0] C_039   = dec_q(64'd39000000000000000);
   localparam logic [63:0] C_057   = dec_q(64'd57000000000000000);
   localparam logic [63:0] C_018   = dec_q(64'd18000000000000000);
   localparam logic [63:0] C_030   = dec_q(64'd30000000000000000);
   localparam logic [63:0] C_LN07  = dec_q(64'd35667494393873240);
   localparam logic [63:0] C_LN075 = dec_q(64'd28768207245178093);
   localparam logic [63:0] C_P1    = dec_q(64'd77938821567698780);
   localparam logic [63:0] C_P2    = dec_q(64'd6815528913297467);
   localparam logic [63:0] C_Q1    = dec_q(64'd111272154900886600);
   localparam logic [63:0] C_Q2    = dec_q(64'd23906247097528370);
   localparam logic [63:0] C_ONE   = 64'h1000_0000_0000_0000;
   localparam logic [63:0] C_TWO   = 64'h2000_0000_0000_0000;
   localparam logic [63:0] C_QTR   = 64'h0400_0000_0000_0000;

endpackage

// ===== rtl/l1p_delay.sv =====
// ----------------------------------------------------------------------------
// l1p_delay
// Fixed-length register delay line used to keep side data aligned.
// ----------------------------------------------------------------------------
module l1p_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] pipe_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            pipe_ff[i] <= '0;
         end
      end else begin
         pipe_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign d_out = pipe_ff[DEPTH-1];

endmodule

// ===== rtl/l1p_mul.sv =====
// ----------------------------------------------------------------------------
// l1p_mul
// Pipelined signed Q60 multiplier, 32x32 partial products, rounded to
// nearest with ties away from zero.
// ----------------------------------------------------------------------------
module l1p_mul (
   input  logic                 clock,
   input  l1p_pkg::q60_type     a,
   input  l1p_pkg::q60_type     b,
   output l1p_pkg::q60_type     p
);

   logic [63:0]  am_ff;
   logic [63:0]  bm_ff;
   logic         sg_ff [0:4];
   logic [63:0]  p00_ff;
   logic [63:0]  p01_ff;
   logic [63:0]  p10_ff;
   logic [63:0]  p11_ff;
   logic [63:0]  p00_s2_ff;
   logic [63:0]  p11_s2_ff;
   logic [64:0]  mid_ff;
   logic [64:0]  top_ff;
   logic [63:0]  mag_ff;
   logic [127:0] full_in;
   l1p_pkg::q60_type p_ff;

   assign full_in = {p11_s2_ff, p00_s2_ff} + {31'd0, mid_ff, 32'd0};

   always_ff @(posedge clock) begin
      am_ff    <= a[63] ? 64'(-a) : 64'(a);
      bm_ff    <= b[63] ? 64'(-b) : 64'(b);
      sg_ff[0] <= a[63] ^ b[63];
      for (int i = 1; i < 5; i++) begin
         sg_ff[i] <= sg_ff[i-1];
      end
      p00_ff    <= am_ff[31:0]  * bm_ff[31:0];
      p01_ff    <= am_ff[31:0]  * bm_ff[63:32];
      p10_ff    <= am_ff[63:32] * bm_ff[31:0];
      p11_ff    <= am_ff[63:32] * bm_ff[63:32];
      mid_ff    <= {1'b0, p01_ff} + {1'b0, p10_ff};
      p00_s2_ff <= p00_ff;
      p11_s2_ff <= p11_ff;
      top_ff    <= full_in[123:59];
      mag_ff    <= top_ff[64:1] + {63'd0, top_ff[0]};
      p_ff      <= sg_ff[4] ? $signed(-mag_ff) : $signed(mag_ff);
   end

   assign p = p_ff;

endmodule

// ===== rtl/l1p_div.sv =====
// ----------------------------------------------------------------------------
// l1p_div
// Pipelined restoring divider, one quotient bit per stage, signed Q60
// quotient rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module l1p_div #(
   parameter int INT_BITS = 0
) (
   input  logic             clock,
   input  l1p_pkg::q60_type num,
   input  logic [63:0]      den,
   output l1p_pkg::q60_type quo
);

   // integer steps, fraction steps and one round step
   localparam int STEPS = INT_BITS + l1p_pkg::QB + 1;

   logic [63:0] r_ff   [0:STEPS-1];
   logic [63:0] d_ff   [0:STEPS-1];
   logic [63:0] q_ff   [0:STEPS];
   logic        neg_ff [0:STEPS+1];
   logic [63:0] mag_ff;
   l1p_pkg::q60_type quo_ff;

   always_ff @(posedge clock) begin
      r_ff[0]   <= num[63] ? 64'(-num) : 64'(num);
      d_ff[0]   <= den;
      q_ff[0]   <= '0;
      neg_ff[0] <= num[63];
   end

   for (genvar g = 1; g <= STEPS; g++) begin : g_step
      if (g <= INT_BITS) begin : g_int
         localparam int SHF = INT_BITS - g;
         logic [65:0] trial_in;
         logic        take_in;
         always_comb begin
            trial_in = {2'b00, d_ff[g-1]} << SHF;
            take_in  = {2'b00, r_ff[g-1]} >= trial_in;
         end
         always_ff @(posedge clock) begin
            r_ff[g]   <= take_in ? (r_ff[g-1] - trial_in[63:0]) : r_ff[g-1];
            d_ff[g]   <= d_ff[g-1];
            q_ff[g]   <= {q_ff[g-1][62:0], take_in};
            neg_ff[g] <= neg_ff[g-1];
         end
      end else begin : g_frac
         logic [63:0] rs_in;
         logic        take_in;
         always_comb begin
            rs_in   = {r_ff[g-1][62:0], 1'b0};
            take_in = rs_in >= d_ff[g-1];
         end
         always_ff @(posedge clock) begin
            q_ff[g]   <= {q_ff[g-1][62:0], take_in};
            neg_ff[g] <= neg_ff[g-1];
         end
         if (g < STEPS) begin : g_keep
            always_ff @(posedge clock) begin
               r_ff[g] <= take_in ? (rs_in - d_ff[g-1]) : rs_in;
               d_ff[g] <= d_ff[g-1];
            end
         end
      end
   end

   // last bit is the round bit
   always_ff @(posedge clock) begin
      mag_ff          <= {1'b0, q_ff[STEPS][63:1]} + {63'd0, q_ff[STEPS][0]};
      neg_ff[STEPS+1] <= neg_ff[STEPS];
      quo_ff          <= neg_ff[STEPS+1] ? $signed(-mag_ff) : $signed(mag_ff);
   end

   assign quo = quo_ff;

endmodule

// ===== rtl/l1p_reduce.sv =====
// ----------------------------------------------------------------------------
// l1p_reduce
// Input decode, band check and range reduction of x to the reduced
// argument t, the divisor 2+t and the band offset.
// ----------------------------------------------------------------------------
module l1p_reduce #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 30
) (
   input  logic                     clock,
   input  logic [DATA_WIDTH-1:0]    x_in,
   output l1p_pkg::red_out_type     red_out
);

   localparam int SH = l1p_pkg::QB - FRAC_BITS;
   localparam logic [63:0] MAG_LIMIT = 64'd1 << FRAC_BITS;
   localparam logic [1:0] BAND_MID  = 2'd0;
   localparam logic [1:0] BAND_LOW  = 2'd1;
   localparam logic [1:0] BAND_HIGH = 2'd2;

   typedef struct packed {
      logic        oor;
      logic [1:0]  band;
      logic        msign;
      logic [63:0] alt;
   } side_type;

   // eight steps of long division by seven
   function automatic logic [66:0] div7_byte(input logic [2:0] rem_i,
                                             input logic [63:0] w_i);
      logic [2:0]  rem;
      logic [63:0] w;
      logic [3:0]  rr;
      rem = rem_i;
      w   = w_i;
      for (int k = 0; k < 8; k++) begin
         rr = {rem, w[63]};
         w  = {w[62:0], 1'b0};
         if (rr >= 4'd7) begin
            rem  = 3'(rr - 4'd7);
            w[0] = 1'b1;
         end else begin
            rem = rr[2:0];
         end
      end
      return {rem, w};
   endfunction

   logic [DATA_WIDTH-1:0] mag1_ff;
   logic                  neg1_ff;
   logic [63:0]           xm_in;
   logic                  oor_in;
   logic [1:0]            band_in;
   logic [63:0]           xm2_ff;
   logic                  neg2_ff;
   logic                  oor2_ff;
   logic [1:0]            band2_ff;
   logic [63:0]           m3_ff;
   logic [63:0]           alt3_ff;
   logic                  oor3_ff;
   logic [1:0]            band3_ff;
   logic [63:0]           mmag4_ff;
   side_type              side4_ff;
   logic [63:0]           w_ff    [0:8];
   logic [2:0]            rem_ff  [0:8];
   side_type              side_ff [0:8];
   logic [63:0]           t14_ff;
   logic                  oor14_ff;
   logic [1:0]            band14_ff;
   l1p_pkg::red_out_type  red_ff;

   always_comb begin
      xm_in  = 64'(mag1_ff) << SH;
      oor_in = (64'(mag1_ff) >= MAG_LIMIT)
             || (neg1_ff ? (xm_in > l1p_pkg::C_039) : (xm_in > l1p_pkg::C_057));
      if (oor_in || (xm_in <= l1p_pkg::C_018)) begin
         band_in = BAND_MID;
      end else begin
         band_in = neg1_ff ? BAND_LOW : BAND_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff  <= x_in[DATA_WIDTH-1];
      mag1_ff  <= x_in[DATA_WIDTH-1] ? (~x_in + 1'b1) : x_in;
      // classify
      xm2_ff   <= oor_in ? 64'd0 : xm_in;
      neg2_ff  <= neg1_ff;
      oor2_ff  <= oor_in;
      band2_ff <= band_in;
      // x+0.3 for the low band, 3x+2 for the high band, signed x otherwise
      m3_ff    <= l1p_pkg::C_030 - xm2_ff;
      alt3_ff  <= (band2_ff == BAND_HIGH) ? (xm2_ff + {xm2_ff[62:0], 1'b0} + 64'd2)
                                          : (neg2_ff ? (64'd0 - xm2_ff) : xm2_ff);
      oor3_ff  <= oor2_ff;
      band3_ff <= band2_ff;
      mmag4_ff       <= m3_ff[63] ? (64'd0 - m3_ff) : m3_ff;
      side4_ff.msign <= m3_ff[63];
      side4_ff.alt   <= (band3_ff == BAND_HIGH) ? ({2'b00, alt3_ff[63:2]} - l1p_pkg::C_QTR)
                                                : alt3_ff;
      side4_ff.oor   <= oor3_ff;
      side4_ff.band  <= band3_ff;
      // 10|m| + 3, then divided by seven
      w_ff[0]    <= {mmag4_ff[60:0], 3'b000} + {mmag4_ff[62:0], 1'b0} + 64'd3;
      rem_ff[0]  <= 3'd0;
      side_ff[0] <= side4_ff;
   end

   for (genvar g = 1; g <= 8; g++) begin : g_div7
      logic [66:0] step_in;
      assign step_in = div7_byte(rem_ff[g-1], w_ff[g-1]);
      always_ff @(posedge clock) begin
         rem_ff[g]  <= step_in[66:64];
         w_ff[g]    <= step_in[63:0];
         side_ff[g] <= side_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (side_ff[8].band == BAND_LOW) begin
         t14_ff <= side_ff[8].msign ? (64'd0 - w_ff[8]) : w_ff[8];
      end else begin
         t14_ff <= side_ff[8].alt;
      end
      oor14_ff  <= side_ff[8].oor;
      band14_ff <= side_ff[8].band;
      red_ff.oor <= oor14_ff;
      red_ff.t   <= $signed(t14_ff);
      red_ff.den <= l1p_pkg::C_TWO + t14_ff;
      unique case (band14_ff)
         BAND_LOW:  red_ff.res0 <= $signed(64'd0 - l1p_pkg::C_LN07);
         BAND_HIGH: red_ff.res0 <= $signed(l1p_pkg::C_LN075);
         default:   red_ff.res0 <= '0;
      endcase
   end

   assign red_out = red_ff;

endmodule

// ===== rtl/log1p_range_reduced_rational_core.sv =====
// ----------------------------------------------------------------------------
// log1p_range_reduced_rational_core
// ln(1+x) for signed fixed-point samples by band reduction and a rational
// approximation in u = t/(2+t).
// ----------------------------------------------------------------------------
// Usage: drive req_x_in and raise start; the item is taken at every clock
// edge where start is high, busy never rises, so one item may enter in every
// cycle. Each item gives exactly one result: rsp_valid is high for one cycle
// with rsp_log_out and rsp_out_of_range, in the order the items were
// taken. Throughput is one item per cycle; the latency is set by the two
// bit-per-stage dividers (64 and 65 stages), four six-stage multiplier
// levels, 15 reduction stages and the output rounding stages.
// Arguments below -0.39 or above 0.57 give zero and raise rsp_out_of_range.
// The receiver cannot hold results off; nothing ever stalls.
// A synchronous reset empties the valid line, so no result appears for
// items in flight at reset; data registers outside the delay lines are not cleared.
// ----------------------------------------------------------------------------
module log1p_range_reduced_rational_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 30
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_x_in,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_log_out,
   output logic                         rsp_out_of_range
);

   localparam int SH       = l1p_pkg::QB - FRAC_BITS;
   localparam int LAT_U2   = l1p_pkg::MUL_LAT + 1;
   localparam int LAT_U    = 3 * l1p_pkg::MUL_LAT + 2 + l1p_pkg::div_lat(1);
   localparam int LAT_SIDE = l1p_pkg::div_lat(0) + LAT_U + l1p_pkg::MUL_LAT;
   localparam int TOTAL_LAT = l1p_pkg::RED_LAT + LAT_SIDE + 5;
   localparam logic [63:0] HALF    = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
   localparam logic [63:0] LIM_NEG = 64'd1 << (DATA_WIDTH - 1);
   localparam logic [63:0] LIM_POS = LIM_NEG - 64'd1;

   l1p_pkg::red_out_type red;
   l1p_pkg::q60_type     u;
   l1p_pkg::q60_type     u2;
   l1p_pkg::q60_type     an;
   l1p_pkg::q60_type     bn;
   logic [63:0]          u2d;
   l1p_pkg::q60_type     sn_ff;
   l1p_pkg::q60_type     sd_ff;
   l1p_pkg::q60_type     nn;
   l1p_pkg::q60_type     dd;
   l1p_pkg::q60_type     num_ff;
   logic [63:0]          den_ff;
   l1p_pkg::q60_type     r;
   logic [63:0]          ud;
   l1p_pkg::q60_type     mr;
   logic [64:0]          side_out;
   l1p_pkg::q60_type     res_ff;
   logic [63:0]          hmag_ff;
   logic [63:0]          omag_ff;
   logic [63:0]          sat_ff;
   logic [63:0]          lim_in;
   logic                 rneg1_ff;
   logic                 rneg2_ff;
   logic                 rneg3_ff;
   logic                 oor1_ff;
   logic                 oor2_ff;
   logic                 oor3_ff;
   logic                 oor4_ff;
   logic [DATA_WIDTH-1:0] log_ff;
   logic                 oor_out_ff;
   logic                 vld_out;

   assign busy = 1'b0;

   l1p_reduce #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_reduce (
      .clock   (clock),
      .x_in    (req_x_in),
      .red_out (red)
   );

   // u = t / (2 + t)
   l1p_div #(.INT_BITS(0)) u_div_u (
      .clock (clock),
      .num   (red.t),
      .den   (red.den),
      .quo   (u)
   );

   l1p_mul u_mul_u2 (.clock(clock), .a(u), .b(u), .p(u2));
   l1p_mul u_mul_pn (.clock(clock), .a($signed(l1p_pkg::C_P2)), .b(u2), .p(an));
   l1p_mul u_mul_pd (.clock(clock), .a($signed(l1p_pkg::C_Q2)), .b(u2), .p(bn));

   l1p_delay #(.WIDTH(64), .DEPTH(LAT_U2)) u_dly_u2 (
      .clock (clock),
      .reset (reset),
      .d_in  (u2),
      .d_out (u2d)
   );

   always_ff @(posedge clock) begin
      sn_ff <= an - $signed(l1p_pkg::C_P1);
      sd_ff <= bn - $signed(l1p_pkg::C_Q1);
   end

   l1p_mul u_mul_nn (.clock(clock), .a(sn_ff), .b($signed(u2d)), .p(nn));
   l1p_mul u_mul_dd (.clock(clock), .a(sd_ff), .b($signed(u2d)), .p(dd));

   always_ff @(posedge clock) begin
      num_ff <= $signed(l1p_pkg::C_ONE) + nn;
      den_ff <= l1p_pkg::C_ONE + 64'(dd);
   end

   // numerator over denominator stays below two
   l1p_div #(.INT_BITS(1)) u_div_r (
      .clock (clock),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (r)
   );

   l1p_delay #(.WIDTH(64), .DEPTH(LAT_U)) u_dly_u (
      .clock (clock),
      .reset (reset),
      .d_in  (u),
      .d_out (ud)
   );

   l1p_mul u_mul_out (.clock(clock), .a($signed({ud[62:0], 1'b0})), .b(r), .p(mr));

   l1p_delay #(.WIDTH(65), .DEPTH(LAT_SIDE)) u_dly_side (
      .clock (clock),
      .reset (reset),
      .d_in  ({red.oor, red.res0}),
      .d_out (side_out)
   );

   l1p_delay #(.WIDTH(1), .DEPTH(TOTAL_LAT)) u_dly_vld (
      .clock (clock),
      .reset (reset),
      .d_in  (start & ~busy),
      .d_out (vld_out)
   );

   assign lim_in = rneg2_ff ? LIM_NEG : LIM_POS;

   // offset add, round to the output format, saturate and zero out-of-range items
   always_ff @(posedge clock) begin
      res_ff     <= $signed(side_out[63:0]) + mr;
      oor1_ff    <= side_out[64];
      hmag_ff    <= res_ff[63] ? 64'(-res_ff) : 64'(res_ff);
      rneg1_ff   <= res_ff[63];
      oor2_ff    <= oor1_ff;
      omag_ff    <= (hmag_ff + HALF) >> SH;
      rneg2_ff   <= rneg1_ff;
      oor3_ff    <= oor2_ff;
      sat_ff     <= (omag_ff > lim_in) ? lim_in : omag_ff;
      rneg3_ff   <= rneg2_ff;
      oor4_ff    <= oor3_ff;
      log_ff     <= oor4_ff ? '0
                            : DATA_WIDTH'(rneg3_ff ? (~sat_ff + 64'd1) : sat_ff);
      oor_out_ff <= oor4_ff;
   end

   assign rsp_valid        = vld_out;
   assign rsp_log_out      = $signed(log_ff);
   assign rsp_out_of_range = oor_out_ff;

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_log_out == '0)
      else $error("out of range item with non-zero result");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##TOTAL_LAT rsp_valid)
      else $error("item result missing after pipeline latency");

   a_zero_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_x_in == '0, TOTAL_LAT)
      |-> rsp_log_out == '0 && !rsp_out_of_range)
      else $error("zero argument gave non-zero result");

endmodule

// ===== dv/log1p_range_reduced_rational_checker.sv =====
// ----------------------------------------------------------------------------
// log1p_range_reduced_rational_checker
// Watches the request and response channels of the ln(1+x) core, works out
// the expected result of each accepted item in Q60 and compares results in
// order of arrival.
// ----------------------------------------------------------------------------
module log1p_range_reduced_rational_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_x_in,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_log_out,
   input  logic               rsp_out_of_range,
   output int                 mismatches,
   output int                 pending
);

   typedef l1p_pkg::q60_type q60_type;

   localparam int SHIFT = 30;
   localparam logic [63:0] DEC_ONE = 64'd100000000000000000;
   localparam logic [63:0] Q_ONE   = 64'h1000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] log_val;
      logic               oor;
   } log_result_type;

   log_result_type log_expected_q[$];

   // unsigned n/d with 60 fraction bits, nearest, ties up
   function automatic logic [63:0] q60_quotient(input logic [63:0] n, input logic [63:0] d);
      logic [127:0] wide;
      if (d == 0) return '0;
      wide = ({64'd0, n} << 61) / {64'd0, d};
      return 64'((wide + 128'd1) >> 1);
   endfunction

   function automatic q60_type q60_const(input logic [63:0] digits);
      return q60_type'(q60_quotient(digits, DEC_ONE));
   endfunction

   function automatic logic [63:0] magnitude(input q60_type a);
      return a < 0 ? 64'(-a) : 64'(a);
   endfunction

   function automatic q60_type q60_product(input q60_type a, input q60_type b);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      m = 64'(p >> 60) + {63'd0, p[59]};
      return ((a < 0) != (b < 0)) ? -q60_type'(m) : q60_type'(m);
   endfunction

   function automatic q60_type q60_ratio(input q60_type a, input q60_type b);
      logic [63:0] m;
      if (b <= 0) return '0;
      m = q60_quotient(magnitude(a), 64'(b));
      return a < 0 ? -q60_type'(m) : q60_type'(m);
   endfunction

   function automatic log_result_type predict_log1p(input logic signed [31:0] x_in);
      log_result_type r;
      logic        neg;
      logic [63:0] mag, m_abs, omag, lim;
      q60_type     x, m, t, u, u2, num, den, ratio, acc;
      neg   = x_in[31];
      mag   = neg ? {32'd0, 32'(-x_in)} : {32'd0, x_in};
      r.log_val = '0;
      r.oor     = 1'b1;
      if (neg && mag[31:0] == 32'd0) mag = 64'h8000_0000;
      if (mag >= 64'h4000_0000) return r;
      x = neg ? -q60_type'(mag << SHIFT) : q60_type'(mag << SHIFT);
      if (x < -q60_const(64'd39000000000000000) || x > q60_const(64'd57000000000000000))
         return r;
      if (x < -q60_const(64'd18000000000000000)) begin
         m     = x + q60_const(64'd30000000000000000);
         m_abs = (magnitude(m) * 64'd10 + 64'd3) / 64'd7;
         t     = m < 0 ? -q60_type'(m_abs) : q60_type'(m_abs);
         acc   = -q60_const(64'd35667494393873240);
      end else if (x > q60_const(64'd18000000000000000)) begin
         t   = q60_type'((64'(x) * 64'd3 + 64'd2) >> 2) - q60_type'(Q_ONE >> 2);
         acc = q60_const(64'd28768207245178093);
      end else begin
         t   = x;
         acc = '0;
      end
      u   = q60_ratio(t, q60_type'(Q_ONE << 1) + t);
      u2  = q60_product(u, u);
      num = q60_type'(Q_ONE) + q60_product(-q60_const(64'd77938821567698780)
            + q60_product(q60_const(64'd6815528913297467), u2), u2);
      den = q60_type'(Q_ONE) + q60_product(-q60_const(64'd111272154900886600)
            + q60_product(q60_const(64'd23906247097528370), u2), u2);
      ratio = q60_ratio(num, den);
      acc   = acc + q60_product(u * 2, ratio);
      omag  = (magnitude(acc) + (64'd1 << (SHIFT - 1))) >> SHIFT;
      lim   = (64'd1 << 31) - (acc < 0 ? 64'd0 : 64'd1);
      if (omag > lim) omag = lim;
      r.log_val = acc < 0 ? 32'(-omag) : 32'(omag);
      r.oor     = 1'b0;
      return r;
   endfunction

   assign pending = log_expected_q.size();

   always @(posedge clock) begin
      log_result_type want;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (start && !busy) log_expected_q.push_back(predict_log1p(req_x_in));
         if (rsp_valid) begin
            if (log_expected_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected result: log_out=%0d oor=%0b", rsp_log_out,
                           rsp_out_of_range);
            end else begin
               want = log_expected_q.pop_front();
               if (want.log_val !== rsp_log_out || want.oor !== rsp_out_of_range) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: log_out exp %0d got %0d, oor exp %0b got %0b",
                              want.log_val, rsp_log_out, want.oor, rsp_out_of_range);
               end
            end
         end
      end
   end

endmodule

// ===== dv/log1p_range_reduced_rational_core_tb.sv =====
// ----------------------------------------------------------------------------
// log1p_range_reduced_rational_core_tb
// Drives band edges, range limits and random arguments into the ln(1+x) core
// with idle bursts, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module log1p_range_reduced_rational_core_tb;

   localparam int NUM_RANDOM  = 430;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_x_in;
   logic               rsp_valid;
   logic signed [31:0] rsp_log_out;
   logic               rsp_out_of_range;
   int                 mismatches;
   int                 pending;
   int                 cycle_count = 0;

   log1p_range_reduced_rational_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_in(req_x_in), .rsp_valid(rsp_valid), .rsp_log_out(rsp_log_out),
      .rsp_out_of_range(rsp_out_of_range)
   );

   log1p_range_reduced_rational_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_in(req_x_in), .rsp_valid(rsp_valid), .rsp_log_out(rsp_log_out),
      .rsp_out_of_range(rsp_out_of_range), .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[log1p_range_reduced_rational_core] ERROR");
         $finish;
      end
   end

   // holds the item until it is taken; start stays high into the next item
   task automatic send_item(input logic signed [31:0] x, input bit may_idle);
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      start    <= 1'b1;
      req_x_in <= x;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] random_arg();
      unique case ($urandom_range(0, 9))
         0, 1:    return $signed($urandom());
         2:       return $signed($urandom_range(0, 20)) - 418759320;
         3:       return $signed($urandom_range(0, 20)) + 612032830;
         4:       return $signed($urandom_range(0, 20)) - 193273538;
         5:       return $signed($urandom_range(0, 20)) + 193273518;
         default: return $signed($urandom_range(0, 1030792300)) - 418759400;
      endcase
   endfunction

   logic signed [31:0] edge_args[] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh4000_0000,
      -32'sh4000_0000, 32'sh3fff_ffff, 32'sd612032839, 32'sd612032840,
      -32'sd418759311, -32'sd418759312, 32'sd193273528, 32'sd193273529,
      -32'sd193273528, -32'sd193273529, -32'sd322122547, 32'sd268435456,
      -32'sd268435456, 32'sd536870912, 32'sh5555_5555, -32'sh5555_5556
   };

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_x_in = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (edge_args[i]) send_item(edge_args[i], 1'b0);
      for (int i = 0; i < NUM_RANDOM; i++) send_item(random_arg(), i < NUM_RANDOM * 4 / 5);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0)
         $display("[log1p_range_reduced_rational_core] OK");
      else
         $display("[log1p_range_reduced_rational_core] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/l1p_pkg.sv
rtl/l1p_delay.sv
rtl/l1p_mul.sv
rtl/l1p_div.sv
rtl/l1p_reduce.sv
rtl/log1p_range_reduced_rational_core.sv
dv/log1p_range_reduced_rational_checker.sv
dv/log1p_range_reduced_rational_core_tb.sv
